// ===== sv/tlpp_pkg.sv =====
// Shared types and constants of the thermal and load power policy block.
`timescale 1ns / 1ps
package tlpp_pkg;

   localparam int CORE_W  = 3;
   localparam int FREQ_W  = 24;
   localparam int TEMP_W  = 19;
   localparam int LOAD_W  = 16;
   localparam int MEM_W   = 2;
   localparam int ACT_W   = 2;
   localparam int SLEEP_W = 13;
   localparam int EPP_W   = 8;
   localparam int MASK_W  = 8;
   localparam int CSR_W   = 19;
   localparam int CSRI_W  = 2;
   localparam int MAX_SLOTS = 8;

   // Item kinds.
   localparam logic KIND_INIT = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Register indexes.
   localparam logic [CSRI_W-1:0] CSR_MASK    = 2'd0;
   localparam logic [CSRI_W-1:0] CSR_TRIP    = 2'd1;
   localparam logic [CSRI_W-1:0] CSR_RECOVER = 2'd2;

   localparam logic [MASK_W-1:0]        MASK_RESET    = 8'hFF;
   localparam logic signed [TEMP_W-1:0] TRIP_RESET    = 19'sd85000;
   localparam logic signed [TEMP_W-1:0] RECOVER_RESET = 19'sd78000;

   // Activity classes.
   localparam logic [ACT_W-1:0] ACT_IDLE     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LIGHT    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MODERATE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_HEAVY    = 2'd3;

   // Memory pressure levels.
   localparam logic [MEM_W-1:0] MEM_RISING   = 2'd1;
   localparam logic [MEM_W-1:0] MEM_CRITICAL = 2'd2;

   localparam logic [SLEEP_W-1:0] SLEEP_HEAVY    = 13'd200;
   localparam logic [SLEEP_W-1:0] SLEEP_MODERATE = 13'd1000;
   localparam logic [SLEEP_W-1:0] SLEEP_LIGHT    = 13'd3000;
   localparam logic [SLEEP_W-1:0] SLEEP_IDLE     = 13'd8000;

   localparam logic [EPP_W-1:0] EPP_PERF = 8'd0;
   localparam logic [EPP_W-1:0] EPP_BAL  = 8'd128;
   localparam logic [EPP_W-1:0] EPP_SAVE = 8'd200;

   // Division by twenty: (x >> 2) / 5 as a multiply by ceil(2^24 / 5), exact for
   // every 22-bit operand.
   localparam int DIV5_SHIFT = 24;
   localparam logic [21:0] DIV5_MULT = 22'd3355444;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init_write;   // record an init transfer
      logic load_tick;    // capture the tick fields
      logic classify;     // compute activity, sleep and preference
      logic issue;        // read one core into the walk pipeline
      logic last;         // the issued core is the final one
   } tlpp_cmd_type;

endpackage

// ===== sv/tlpp_ctrl.sv =====
// Controller state machine that sequences init records and policy ticks.
`timescale 1ns / 1ps
module tlpp_ctrl
   import tlpp_pkg::*;
#(
   parameter int SLOTS = 8,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             kind,
   output logic             busy,
   output tlpp_cmd_type     cmd,
   output logic [IDX_W-1:0] walk_idx
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLASS = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               if (kind == KIND_TICK) begin
                  cmd.load_tick = 1'b1;
                  state_in      = ST_CLASS;
               end else begin
                  cmd.init_write = 1'b1;
               end
            end
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            cmd.last  = (idx_ff == LAST_IDX);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign walk_idx = idx_ff;

endmodule

// ===== sv/tlpp_dpath.sv =====
// Datapath: registers, per-core state, tick classification and the core walk pipeline.
`timescale 1ns / 1ps
module tlpp_dpath
   import tlpp_pkg::*;
#(
   parameter int SLOTS = 8,
   parameter int IDX_W = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tlpp_cmd_type              cmd,
   input  logic [IDX_W-1:0]          walk_idx,
   input  logic                      csr_we,
   input  logic [CSRI_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic [CORE_W-1:0]         req_core_index,
   input  logic [FREQ_W-1:0]         req_freq_khz,
   input  logic signed [TEMP_W-1:0]  req_peak_temp_mdeg,
   input  logic [LOAD_W-1:0]         req_load_avg_q,
   input  logic [MEM_W-1:0]          req_mem_level,
   output logic                      rsp_strobe,
   output logic [ACT_W-1:0]          rsp_activity,
   output logic [SLEEP_W-1:0]        rsp_interval_ms,
   output logic [EPP_W-1:0]          rsp_epp_choice,
   output logic [CORE_W-1:0]         rsp_out_core,
   output logic                      rsp_core_valid,
   output logic [FREQ_W-1:0]         rsp_cap_khz,
   output logic                      rsp_cap_changed,
   output logic                      rsp_epp_changed,
   output logic                      rsp_last
);

   localparam int CNT_W = 4;
   localparam int THR_W = 21;
   localparam logic [CORE_W:0] SLOTS_C = (CORE_W + 1)'(SLOTS);

   // Configuration registers.
   logic [MASK_W-1:0]        mask_ff;
   logic signed [TEMP_W-1:0] trip_ff;
   logic signed [TEMP_W-1:0] recover_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         trip_ff    <= TRIP_RESET;
         recover_ff <= RECOVER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MASK:    mask_ff    <= csr_wdata[MASK_W-1:0];
            CSR_TRIP:    trip_ff    <= csr_wdata;
            CSR_RECOVER: recover_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Per-core state.
   logic [FREQ_W-1:0] orig_cap_ff [0:SLOTS-1];
   logic [FREQ_W-1:0] cur_cap_ff  [0:SLOTS-1];
   logic [EPP_W-1:0]  epp_val_ff  [0:SLOTS-1];
   logic [SLOTS-1:0]  known_ff;
   logic [SLOTS-1:0]  epp_wr_ff;

   // Tick fields and classification.
   logic signed [TEMP_W-1:0] peak_ff;
   logic [LOAD_W-1:0]        load_ff;
   logic [MEM_W-1:0]         mem_ff;
   logic [ACT_W-1:0]         act_ff, act_in;
   logic [SLEEP_W-1:0]       sleep_ff, sleep_in;
   logic [EPP_W-1:0]         epp_ff, epp_in;
   logic                     over_ff, recov_ff, any_on_ff;

   logic [CNT_W-1:0] online_n;
   logic [THR_W-1:0] load_x5, load_x20, n_x1024, n_x256;
   logic             over_c, heavy_load, above_idle, below_light;

   always_comb begin
      online_n = '0;
      for (int i = 0; i < SLOTS; i++) begin
         online_n = online_n + CNT_W'(mask_ff[i]);
      end
   end

   always_comb begin
      load_x5  = THR_W'(load_ff) * THR_W'(5);
      load_x20 = THR_W'(load_ff) * THR_W'(20);
      n_x1024  = THR_W'(online_n) << 10;
      n_x256   = THR_W'(online_n) << 8;
      over_c      = (peak_ff > trip_ff);
      heavy_load  = (online_n != '0) && (load_x5 > n_x1024);
      above_idle  = (online_n != '0) && (load_x20 > n_x256);
      below_light = (online_n == '0) || (load_x5 < n_x256);

      if (over_c || mem_ff >= MEM_CRITICAL) begin
         act_in = ACT_HEAVY;
      end else if (mem_ff == MEM_RISING || heavy_load) begin
         act_in = ACT_MODERATE;
      end else if (above_idle) begin
         act_in = ACT_LIGHT;
      end else begin
         act_in = ACT_IDLE;
      end

      if (act_in == ACT_IDLE) begin
         epp_in = EPP_SAVE;
      end else if (heavy_load) begin
         epp_in = EPP_PERF;
      end else if (below_light) begin
         epp_in = EPP_SAVE;
      end else begin
         epp_in = EPP_BAL;
      end

      case (act_in)
         ACT_HEAVY:    sleep_in = SLEEP_HEAVY;
         ACT_MODERATE: sleep_in = SLEEP_MODERATE;
         ACT_LIGHT:    sleep_in = SLEEP_LIGHT;
         default:      sleep_in = SLEEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         peak_ff <= req_peak_temp_mdeg;
         load_ff <= req_load_avg_q;
         mem_ff  <= req_mem_level;
      end
      if (cmd.classify) begin
         act_ff    <= act_in;
         sleep_ff  <= sleep_in;
         epp_ff    <= epp_in;
         over_ff   <= over_c;
         recov_ff  <= (peak_ff <= recover_ff);
         any_on_ff <= (online_n != '0);
      end
   end

   // Walk stage one: read the core and register its cap divided by twenty.
   logic              s1_valid_ff, s1_last_ff, s1_on_ff, s1_known_ff, s1_eppw_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [FREQ_W-1:0] s1_cur_ff, s1_orig_ff;
   logic [19:0]       s1_q_ff;
   logic [EPP_W-1:0]  s1_eppv_ff;
   logic [43:0]       div_prod;

   assign div_prod = 44'(cur_cap_ff[walk_idx][FREQ_W-1:2]) * 44'(DIV5_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
      s1_last_ff  <= cmd.last;
      s1_idx_ff   <= walk_idx;
      s1_on_ff    <= mask_ff[walk_idx];
      s1_known_ff <= known_ff[walk_idx];
      s1_eppw_ff  <= epp_wr_ff[walk_idx];
      s1_eppv_ff  <= epp_val_ff[walk_idx];
      s1_cur_ff   <= cur_cap_ff[walk_idx];
      s1_orig_ff  <= orig_cap_ff[walk_idx];
      s1_q_ff     <= div_prod[DIV5_SHIFT+19:DIV5_SHIFT];
   end

   // Walk stage two: new cap, preference update and the result register.
   logic              valid_c, cap_chg_c, epp_chg_c;
   logic [FREQ_W-1:0] red_c, flo_c, tgt_c;

   always_comb begin
      valid_c = s1_on_ff && s1_known_ff;
      red_c   = s1_cur_ff - FREQ_W'(s1_q_ff);
      flo_c   = s1_orig_ff >> 1;
      if (over_ff) begin
         tgt_c = (red_c < flo_c) ? flo_c : red_c;
      end else if (recov_ff && s1_cur_ff < s1_orig_ff) begin
         tgt_c = s1_orig_ff;
      end else begin
         tgt_c = s1_cur_ff;
      end
      cap_chg_c = valid_c && (tgt_c != s1_cur_ff);
      epp_chg_c = s1_on_ff && any_on_ff && (!s1_eppw_ff || s1_eppv_ff != epp_ff);
   end

   logic init_ok;
   assign init_ok = cmd.init_write && ({1'b0, req_core_index} < SLOTS_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         epp_wr_ff <= '0;
      end else begin
         if (init_ok) begin
            known_ff[IDX_W'(req_core_index)] <= 1'b1;
         end
         if (s1_valid_ff && epp_chg_c) begin
            epp_wr_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (init_ok) begin
         orig_cap_ff[IDX_W'(req_core_index)] <= req_freq_khz;
         cur_cap_ff[IDX_W'(req_core_index)]  <= req_freq_khz;
      end else if (s1_valid_ff && cap_chg_c) begin
         cur_cap_ff[s1_idx_ff] <= tgt_c;
      end
      if (s1_valid_ff && epp_chg_c) begin
         epp_val_ff[s1_idx_ff] <= epp_ff;
      end
   end

   logic rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_activity    <= act_ff;
      rsp_interval_ms <= sleep_ff;
      rsp_epp_choice  <= epp_ff;
      rsp_out_core    <= CORE_W'(s1_idx_ff);
      rsp_core_valid  <= valid_c;
      rsp_cap_khz     <= valid_c ? tgt_c : '0;
      rsp_cap_changed <= cap_chg_c;
      rsp_epp_changed <= epp_chg_c;
      rsp_last        <= s1_last_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== sv/thermal_load_power_policy_top.sv =====
// Top level of the thermal and load power policy block.
//
//   channel   direction  handshake           payload
//   req_      in         start, busy         kind, core index, frequency, peak, load, memory
//   rsp_      out        rsp_strobe          activity, interval, preference, core, cap, flags
//   csr_      in         csr_we              csr_index, csr_wdata
//
// An init transfer is taken while busy stays low, so init records can follow
// each other on every cycle. A tick holds busy high through a classify state,
// a walk state that issues each of the NUM_CORES (at most eight) cores in turn
// into a two-stage walk pipeline, and a drain state; the per-core results come
// out on consecutive cycles, one per core, the last one marked by rsp_last.
// The walk is set by the single read port of the per-core cap store and the
// shared divide-by-twenty multiplier. Reset is synchronous and active high; it
// loads the register defaults and clears the known and preference-written
// flags. The receiver cannot stall, so every result transfer completes in the
// one cycle its strobe is high.
`timescale 1ns / 1ps
module thermal_load_power_policy_top
   import tlpp_pkg::*;
#(
   parameter int NUM_CORES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_kind,
   input  logic [CORE_W-1:0]         req_core_index,
   input  logic [FREQ_W-1:0]         req_freq_khz,
   input  logic signed [TEMP_W-1:0]  req_peak_temp_mdeg,
   input  logic [LOAD_W-1:0]         req_load_avg_q,
   input  logic [MEM_W-1:0]          req_mem_level,
   output logic                      rsp_strobe,
   output logic [ACT_W-1:0]          rsp_activity,
   output logic [SLEEP_W-1:0]        rsp_interval_ms,
   output logic [EPP_W-1:0]          rsp_epp_choice,
   output logic [CORE_W-1:0]         rsp_out_core,
   output logic                      rsp_core_valid,
   output logic [FREQ_W-1:0]         rsp_cap_khz,
   output logic                      rsp_cap_changed,
   output logic                      rsp_epp_changed,
   output logic                      rsp_last,
   input  logic                      csr_we,
   input  logic [CSRI_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   // Only the first eight cores have slots; higher cores are never reported.
   localparam int SLOTS = (NUM_CORES < MAX_SLOTS) ? NUM_CORES : MAX_SLOTS;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   tlpp_cmd_type     cmd;
   logic [IDX_W-1:0] walk_idx;

   // The controller decides when an item is taken and steps the core walk.
   tlpp_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .kind     (req_kind),
      .busy     (busy),
      .cmd      (cmd),
      .walk_idx (walk_idx)
   );

   // The datapath holds the registers, the per-core state and the result register.
   tlpp_dpath #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .walk_idx           (walk_idx),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_core_index     (req_core_index),
      .req_freq_khz       (req_freq_khz),
      .req_peak_temp_mdeg (req_peak_temp_mdeg),
      .req_load_avg_q     (req_load_avg_q),
      .req_mem_level      (req_mem_level),
      .rsp_strobe         (rsp_strobe),
      .rsp_activity       (rsp_activity),
      .rsp_interval_ms    (rsp_interval_ms),
      .rsp_epp_choice     (rsp_epp_choice),
      .rsp_out_core       (rsp_out_core),
      .rsp_core_valid     (rsp_core_valid),
      .rsp_cap_khz        (rsp_cap_khz),
      .rsp_cap_changed    (rsp_cap_changed),
      .rsp_epp_changed    (rsp_epp_changed),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== sv/tlpp_checker.sv =====
// Port-level checker of the thermal and load power policy block, with its bind.
`timescale 1ns / 1ps
module tlpp_checker
   import tlpp_pkg::*;
#(
   parameter int NUM_CORES = 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      req_kind,
   input logic                      rsp_strobe,
   input logic [CORE_W-1:0]         rsp_out_core,
   input logic                      rsp_core_valid,
   input logic [FREQ_W-1:0]         rsp_cap_khz,
   input logic                      rsp_cap_changed,
   input logic                      rsp_last
);

   localparam int SLOTS = (NUM_CORES < MAX_SLOTS) ? NUM_CORES : MAX_SLOTS;
   localparam logic [CORE_W-1:0] LAST_CORE = CORE_W'(SLOTS - 1);

   // Busy only rises after a tick transfer.
   a_busy_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_kind == KIND_TICK))
      else $error("busy rose without a tick transfer");

   // Results only follow a busy cycle.
   a_rsp_in_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result outside a tick");

   // The final result reports the highest core.
   a_last_core: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (rsp_out_core == LAST_CORE))
      else $error("last result on the wrong core");

   // Results of one tick are back to back in core order.
   a_core_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=>
         (rsp_strobe && rsp_out_core == $past(rsp_out_core) + 3'd1))
      else $error("core results out of order");

   // A core without a valid record has no cap.
   a_invalid_core: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_core_valid) |-> (rsp_cap_khz == '0 && !rsp_cap_changed))
      else $error("cap reported for an invalid core");

endmodule

bind thermal_load_power_policy_top tlpp_checker #(.NUM_CORES(NUM_CORES)) u_tlpp_checker (.*);
